@@ rtl/e13ewd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e13ewd_pkg
// Shared types, constants and lookup tables of the EAN-13 element width
// decoder.
// ----------------------------------------------------------------------------
package e13ewd_pkg;

    // Row layout in elements.
    localparam logic [5:0] ROW_LEN     = 6'd59;
    localparam logic [5:0] LEFT_FIRST  = 6'd3;
    localparam logic [5:0] LEFT_LAST   = 6'd26;
    localparam logic [5:0] RIGHT_FIRST = 6'd32;
    localparam logic [5:0] RIGHT_LAST  = 6'd55;
    localparam logic [1:0] GRP_LAST    = 2'd3;

    localparam logic [3:0] POS_LEAD    = 4'd0;
    localparam logic [3:0] POS_LEFT0   = 4'd1;
    localparam logic [3:0] POS_RIGHT0  = 4'd7;

    // Decode method codes.
    localparam logic [1:0] METHOD_MODULE = 2'd0;
    localparam logic [1:0] METHOD_EDGE   = 2'd1;
    localparam logic [1:0] METHOD_NONE   = 2'd2;

    // Edge distance classes 2 to 5 sevenths, coded from zero.
    localparam logic [1:0] ECLS_2 = 2'd0;
    localparam logic [1:0] ECLS_3 = 2'd1;
    localparam logic [1:0] ECLS_4 = 2'd2;
    localparam logic [1:0] ECLS_5 = 2'd3;

    // Width scale: 95 modules times two, so that half-module bounds are odd
    // multiples of the span.
    localparam int MOD_SCALE = 190;
    localparam int SPAN_W    = 16;
    localparam int SPANX_W   = 20;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd190;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    // Module counts of the four elements, first element in the top nibble.
    localparam logic [15:0] L_CODES [10] = '{
        16'h3211, 16'h2221, 16'h2122, 16'h1411, 16'h1132,
        16'h1231, 16'h1114, 16'h1312, 16'h1213, 16'h3112};
    localparam logic [15:0] G_CODES [10] = '{
        16'h1123, 16'h1222, 16'h2212, 16'h1141, 16'h2311,
        16'h1321, 16'h4111, 16'h2131, 16'h3121, 16'h2113};

    // Odd multiples of the symbol span used as module boundaries.
    typedef struct packed {
        logic [SPANX_W-1:0] x1;
        logic [SPANX_W-1:0] x3;
        logic [SPANX_W-1:0] x5;
        logic [SPANX_W-1:0] x7;
        logic [SPANX_W-1:0] x9;
    } span_mult_t;

    // Both decodings of one digit group.
    typedef struct packed {
        logic       mod_ok;
        logic [3:0] mod_digit;
        logic       mod_g;
        logic       edge_ok;
        logic [3:0] edge_digit;
        logic       edge_g;
    } dig_t;

    // One result word.
    typedef struct packed {
        logic       done;
        logic [1:0] method;
        logic       valid;
        logic [3:0] value;
        logic [3:0] position;
    } res_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } lead_t;

    // Lead digit from the left half parity pattern, G as a one.
    function automatic lead_t lead_lookup(input logic [5:0] pattern);
        lead_t r;
        r.hit = 1'b1;
        case (pattern)
            6'd0:    r.value = 4'd0;
            6'd11:   r.value = 4'd1;
            6'd13:   r.value = 4'd2;
            6'd14:   r.value = 4'd3;
            6'd19:   r.value = 4'd4;
            6'd25:   r.value = 4'd5;
            6'd28:   r.value = 4'd6;
            6'd21:   r.value = 4'd7;
            6'd22:   r.value = 4'd8;
            6'd26:   r.value = 4'd9;
            default: begin
                r.hit   = 1'b0;
                r.value = 4'd0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/e13ewd_quant.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e13ewd_quant
// Quantizes one element width to one to four modules against the symbol span.
// ----------------------------------------------------------------------------
module e13ewd_quant #(
    parameter int WIDTH_BITS = 10
) (
    input  logic [WIDTH_BITS-1:0]   width,
    input  e13ewd_pkg::span_mult_t  span,
    output logic [1:0]              mod_class   // modules minus one
);

    localparam int CMP_W = (WIDTH_BITS + 8 > e13ewd_pkg::SPANX_W) ?
                           WIDTH_BITS + 8 : e13ewd_pkg::SPANX_W;

    logic [CMP_W-1:0] scaled;
    logic [CMP_W-1:0] b1, b3, b5, b7, b9;

    assign scaled = CMP_W'(width) * CMP_W'(e13ewd_pkg::MOD_SCALE);
    assign b1 = CMP_W'(span.x1);
    assign b3 = CMP_W'(span.x3);
    assign b5 = CMP_W'(span.x5);
    assign b7 = CMP_W'(span.x7);
    assign b9 = CMP_W'(span.x9);

    // Anything below one half module or above four and a half counts as one.
    always_comb begin
        mod_class = 2'd0;
        if (scaled >= b1) begin
            if (scaled < b3) begin
                mod_class = 2'd0;
            end else if (scaled < b5) begin
                mod_class = 2'd1;
            end else if (scaled < b7) begin
                mod_class = 2'd2;
            end else if (scaled < b9) begin
                mod_class = 2'd3;
            end
        end
    end

endmodule

@@ rtl/e13ewd_digit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e13ewd_digit
// Decodes one four-element group by module pattern and by edge distance key.
// ----------------------------------------------------------------------------
module e13ewd_digit #(
    parameter int WIDTH_BITS = 10
) (
    input  logic [3:0][WIDTH_BITS-1:0] widths,
    input  logic [3:0][1:0]            mod_class,
    output e13ewd_pkg::dig_t           dig
);

    localparam int EW = WIDTH_BITS + 6;

    logic [15:0]   code;
    logic [EW-1:0] t1, t2, tot;
    logic [1:0]    ec1, ec2;

    function automatic logic [1:0] edge_class(input logic [EW-1:0] t,
                                              input logic [EW-1:0] total);
        logic [1:0] c;
        if (t * EW'(14) < total * EW'(5)) begin
            c = e13ewd_pkg::ECLS_2;
        end else if (t * EW'(2) < total) begin
            c = e13ewd_pkg::ECLS_3;
        end else if (t * EW'(14) < total * EW'(9)) begin
            c = e13ewd_pkg::ECLS_4;
        end else begin
            c = e13ewd_pkg::ECLS_5;
        end
        return c;
    endfunction

    assign code = {4'(mod_class[0]) + 4'd1, 4'(mod_class[1]) + 4'd1,
                   4'(mod_class[2]) + 4'd1, 4'(mod_class[3]) + 4'd1};

    assign t1  = EW'(widths[0]) + EW'(widths[1]);
    assign t2  = EW'(widths[1]) + EW'(widths[2]);
    assign tot = t1 + EW'(widths[2]) + EW'(widths[3]);
    assign ec1 = edge_class(t1, tot);
    assign ec2 = edge_class(t2, tot);

    always_comb begin
        dig = '0;
        // Scan from the top down so that the lowest L digit wins.
        for (int d = 9; d >= 0; d--) begin
            if (code == e13ewd_pkg::G_CODES[d]) begin
                dig.mod_ok    = 1'b1;
                dig.mod_digit = 4'(d);
                dig.mod_g     = 1'b1;
            end
        end
        for (int d = 9; d >= 0; d--) begin
            if (code == e13ewd_pkg::L_CODES[d]) begin
                dig.mod_ok    = 1'b1;
                dig.mod_digit = 4'(d);
                dig.mod_g     = 1'b0;
            end
        end

        dig.edge_ok = 1'b1;
        case ({ec1, ec2})
            {e13ewd_pkg::ECLS_4, e13ewd_pkg::ECLS_4}: begin
                dig.edge_digit = (widths[2] > widths[3]) ? 4'd1 : 4'd7;
            end
            {e13ewd_pkg::ECLS_3, e13ewd_pkg::ECLS_3}: begin
                dig.edge_digit = (widths[1] > widths[2]) ? 4'd8 : 4'd2;
            end
            {e13ewd_pkg::ECLS_3, e13ewd_pkg::ECLS_4}: begin
                dig.edge_digit = (widths[0] > widths[1]) ? 4'd7 : 4'd1;
                dig.edge_g     = 1'b1;
            end
            {e13ewd_pkg::ECLS_4, e13ewd_pkg::ECLS_3}: begin
                dig.edge_digit = (widths[1] > widths[2]) ? 4'd2 : 4'd8;
                dig.edge_g     = 1'b1;
            end
            {e13ewd_pkg::ECLS_5, e13ewd_pkg::ECLS_3}: dig.edge_digit = 4'd0;
            {e13ewd_pkg::ECLS_5, e13ewd_pkg::ECLS_5}: dig.edge_digit = 4'd3;
            {e13ewd_pkg::ECLS_2, e13ewd_pkg::ECLS_4}: dig.edge_digit = 4'd4;
            {e13ewd_pkg::ECLS_3, e13ewd_pkg::ECLS_5}: dig.edge_digit = 4'd5;
            {e13ewd_pkg::ECLS_2, e13ewd_pkg::ECLS_2}: dig.edge_digit = 4'd6;
            {e13ewd_pkg::ECLS_4, e13ewd_pkg::ECLS_2}: dig.edge_digit = 4'd9;
            {e13ewd_pkg::ECLS_2, e13ewd_pkg::ECLS_3}: begin
                dig.edge_digit = 4'd0;
                dig.edge_g     = 1'b1;
            end
            {e13ewd_pkg::ECLS_2, e13ewd_pkg::ECLS_5}: begin
                dig.edge_digit = 4'd3;
                dig.edge_g     = 1'b1;
            end
            {e13ewd_pkg::ECLS_5, e13ewd_pkg::ECLS_4}: begin
                dig.edge_digit = 4'd4;
                dig.edge_g     = 1'b1;
            end
            {e13ewd_pkg::ECLS_4, e13ewd_pkg::ECLS_5}: begin
                dig.edge_digit = 4'd5;
                dig.edge_g     = 1'b1;
            end
            {e13ewd_pkg::ECLS_5, e13ewd_pkg::ECLS_2}: begin
                dig.edge_digit = 4'd6;
                dig.edge_g     = 1'b1;
            end
            {e13ewd_pkg::ECLS_3, e13ewd_pkg::ECLS_2}: begin
                dig.edge_digit = 4'd9;
                dig.edge_g     = 1'b1;
            end
            default: dig.edge_ok = 1'b0;
        endcase
    end

endmodule

@@ rtl/e13ewd_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e13ewd_outq
// Four-word result queue that takes up to two words per cycle.
// ----------------------------------------------------------------------------
module e13ewd_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push0,
    input  e13ewd_pkg::res_t   data0,
    input  logic               push1,      // only together with push0
    input  e13ewd_pkg::res_t   data1,
    output logic               room,       // at least two free entries
    output logic               m_valid,
    input  logic               m_ready,
    output e13ewd_pkg::res_t   m_data
);

    localparam int PW = e13ewd_pkg::OUTQ_PTR_W;
    localparam int CW = e13ewd_pkg::OUTQ_CNT_W;

    e13ewd_pkg::res_t outq_mem_reg [e13ewd_pkg::OUTQ_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    push_n;
    logic          pop;

    assign push_n  = push1 ? 2'd2 : (push0 ? 2'd1 : 2'd0);
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid & m_ready;
    assign m_data  = outq_mem_reg[rd_ptr_reg];
    assign room    = (count_reg <= CW'(e13ewd_pkg::OUTQ_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            outq_mem_reg[wr_ptr_reg] <= data0;
        end
        if (push1) begin
            outq_mem_reg[wr_ptr_reg + PW'(1)] <= data1;
        end
    end

endmodule

@@ rtl/ean13_element_width_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean13_element_width_decoder
// Decodes the 59 bar and space widths of an EAN-13 row into 13 digits.
// ----------------------------------------------------------------------------
// The block takes one element width per cycle, sustained, and keeps that pace
// as long as the result side takes words. Each width passes once through the
// input register, the quantizers and the digit decoder and lands in a four-word
// result queue; the word for a group is written from the input register into the
// queue once it has room and is offered from there. The fourth width of each
// digit group yields one word, and
// the last data element of the row yields two (digit 12 and then the lead
// digit with tlast set), which the queue absorbs since it takes two words in
// one cycle. Widths after the end guard are dropped until the next row start.
// symbol_span may only be written while the block is idle; there is no
// clearing pass after reset.
module ean13_element_width_decoder #(
    parameter int WIDTH_BITS = 10,
    localparam int S_TDATA_W = ((WIDTH_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [15:0]          cfg_wdata,       // symbol_span
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,    // element_width
    input  logic [0:0]           s_axis_tuser,    // row_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,    // digit_position, digit_value
    output logic [2:0]           m_axis_tuser,    // digit_valid, decode_method
    output logic                 m_axis_tlast     // row_done
);

    e13ewd_pkg::span_mult_t span_reg, span_next;

    logic                  in_valid_reg, in_valid_next;
    logic [WIDTH_BITS-1:0] in_width_reg;
    logic                  in_start_reg;

    logic [5:0] elem_idx_reg, elem_idx_next;
    logic [5:0] par_mod_reg, par_mod_next;
    logic [5:0] par_edge_reg, par_edge_next;

    logic [WIDTH_BITS-1:0] grp_width_reg [3];
    logic [2:0][1:0]       grp_class;

    logic       in_fire, proceed, room;
    logic [5:0] idx_eff, par_mod_base, par_edge_base, par_bit;
    logic       active, left, right, grp_end, lead_now;
    logic [4:0] rel;
    logic [1:0] grp_pos;
    logic [3:0] dig_pos;
    logic [1:0] cur_class;

    e13ewd_pkg::dig_t  dig;
    e13ewd_pkg::lead_t lead_m, lead_e;
    e13ewd_pkg::res_t  res_digit, res_lead, head;
    logic              push0, push1;

    // Configuration: keep the odd multiples of the span ready for compares.
    always_comb begin
        span_next = span_reg;
        if (cfg_wen) begin
            span_next.x1 = e13ewd_pkg::SPANX_W'(cfg_wdata);
            span_next.x3 = e13ewd_pkg::SPANX_W'(cfg_wdata) * e13ewd_pkg::SPANX_W'(3);
            span_next.x5 = e13ewd_pkg::SPANX_W'(cfg_wdata) * e13ewd_pkg::SPANX_W'(5);
            span_next.x7 = e13ewd_pkg::SPANX_W'(cfg_wdata) * e13ewd_pkg::SPANX_W'(7);
            span_next.x9 = e13ewd_pkg::SPANX_W'(cfg_wdata) * e13ewd_pkg::SPANX_W'(9);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_reg.x1 <= e13ewd_pkg::SPANX_W'(e13ewd_pkg::SPAN_RESET);
            span_reg.x3 <= e13ewd_pkg::SPANX_W'(e13ewd_pkg::SPAN_RESET)
                           * e13ewd_pkg::SPANX_W'(3);
            span_reg.x5 <= e13ewd_pkg::SPANX_W'(e13ewd_pkg::SPAN_RESET)
                           * e13ewd_pkg::SPANX_W'(5);
            span_reg.x7 <= e13ewd_pkg::SPANX_W'(e13ewd_pkg::SPAN_RESET)
                           * e13ewd_pkg::SPANX_W'(7);
            span_reg.x9 <= e13ewd_pkg::SPANX_W'(e13ewd_pkg::SPAN_RESET)
                           * e13ewd_pkg::SPANX_W'(9);
        end else begin
            span_reg <= span_next;
        end
    end

    // Input register.
    assign proceed       = in_valid_reg & room;
    assign s_axis_tready = ~in_valid_reg | proceed;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (proceed) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_width_reg <= s_axis_tdata[WIDTH_BITS-1:0];
            in_start_reg <= s_axis_tuser[0];
        end
    end

    // Position of the word within the row.
    always_comb begin
        idx_eff       = in_start_reg ? 6'd0 : elem_idx_reg;
        par_mod_base  = in_start_reg ? 6'd0 : par_mod_reg;
        par_edge_base = in_start_reg ? 6'd0 : par_edge_reg;
        active   = (idx_eff < e13ewd_pkg::ROW_LEN);
        left     = (idx_eff >= e13ewd_pkg::LEFT_FIRST) && (idx_eff <= e13ewd_pkg::LEFT_LAST);
        right    = (idx_eff >= e13ewd_pkg::RIGHT_FIRST) && (idx_eff <= e13ewd_pkg::RIGHT_LAST);
        rel      = left ? 5'(idx_eff - e13ewd_pkg::LEFT_FIRST)
                        : 5'(idx_eff - e13ewd_pkg::RIGHT_FIRST);
        grp_pos  = rel[1:0];
        grp_end  = (left | right) && (grp_pos == e13ewd_pkg::GRP_LAST);
        lead_now = (idx_eff == e13ewd_pkg::RIGHT_LAST);
        dig_pos  = 4'(rel[4:2]) + (left ? e13ewd_pkg::POS_LEFT0 : e13ewd_pkg::POS_RIGHT0);
        // Digit 1 owns the top bit of the parity pattern.
        par_bit  = 6'b100000 >> rel[4:2];
    end

    e13ewd_quant #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_quant (
        .width     (in_width_reg),
        .span      (span_reg),
        .mod_class (cur_class)
    );

    // Stored widths are quantized against the span in force at the group end.
    for (genvar g = 0; g < 3; g++) begin : g_grp_quant
        e13ewd_quant #(
            .WIDTH_BITS (WIDTH_BITS)
        ) u_quant (
            .width     (grp_width_reg[g]),
            .span      (span_reg),
            .mod_class (grp_class[g])
        );
    end

    e13ewd_digit #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_digit (
        .widths    ({in_width_reg, grp_width_reg[2], grp_width_reg[1], grp_width_reg[0]}),
        .mod_class ({cur_class, grp_class[2], grp_class[1], grp_class[0]}),
        .dig       (dig)
    );

    // Row state update.
    always_comb begin
        elem_idx_next = elem_idx_reg;
        par_mod_next  = par_mod_reg;
        par_edge_next = par_edge_reg;
        if (proceed) begin
            elem_idx_next = active ? idx_eff + 6'd1 : idx_eff;
            par_mod_next  = par_mod_base;
            par_edge_next = par_edge_base;
            if (grp_end && left) begin
                if (dig.mod_ok && dig.mod_g) begin
                    par_mod_next = par_mod_base | par_bit;
                end
                if (dig.edge_ok && dig.edge_g) begin
                    par_edge_next = par_edge_base | par_bit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_idx_reg <= '0;
            par_mod_reg  <= '0;
            par_edge_reg <= '0;
        end else begin
            elem_idx_reg <= elem_idx_next;
            par_mod_reg  <= par_mod_next;
            par_edge_reg <= par_edge_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && (left || right) && (grp_pos != e13ewd_pkg::GRP_LAST)) begin
            grp_width_reg[grp_pos] <= in_width_reg;
        end
    end

    // Result words.
    always_comb begin
        res_digit.position = dig_pos;
        res_digit.done     = 1'b0;
        if (dig.mod_ok) begin
            res_digit.value  = dig.mod_digit;
            res_digit.valid  = 1'b1;
            res_digit.method = e13ewd_pkg::METHOD_MODULE;
        end else if (dig.edge_ok) begin
            res_digit.value  = dig.edge_digit;
            res_digit.valid  = 1'b1;
            res_digit.method = e13ewd_pkg::METHOD_EDGE;
        end else begin
            res_digit.value  = 4'd0;
            res_digit.valid  = 1'b0;
            res_digit.method = e13ewd_pkg::METHOD_NONE;
        end

        // The last right-half digit adds no parity, so the base patterns hold.
        lead_m = e13ewd_pkg::lead_lookup(par_mod_base);
        lead_e = e13ewd_pkg::lead_lookup(par_edge_base);
        res_lead.position = e13ewd_pkg::POS_LEAD;
        res_lead.done     = 1'b1;
        if (lead_m.hit) begin
            res_lead.value  = lead_m.value;
            res_lead.valid  = 1'b1;
            res_lead.method = e13ewd_pkg::METHOD_MODULE;
        end else if (lead_e.hit) begin
            res_lead.value  = lead_e.value;
            res_lead.valid  = 1'b1;
            res_lead.method = e13ewd_pkg::METHOD_EDGE;
        end else begin
            res_lead.value  = 4'd0;
            res_lead.valid  = 1'b0;
            res_lead.method = e13ewd_pkg::METHOD_NONE;
        end
    end

    assign push0 = proceed & grp_end;
    assign push1 = proceed & grp_end & lead_now;

    e13ewd_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push0   (push0),
        .data0   (res_digit),
        .push1   (push1),
        .data1   (res_lead),
        .room    (room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (head)
    );

    assign m_axis_tdata = {head.value, head.position};
    assign m_axis_tuser = {head.method, head.valid};
    assign m_axis_tlast = head.done;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the EAN-13 element width decoder. Rows of widths
// built from random digit strings, with jitter, ink spread, noise, cut rows
// and trailing elements, are streamed in under random stalls on both sides.
// A behavioral predictor computes each digit word, and the monitor checks
// every received word against the oldest prediction. Several symbol spans
// are programmed between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WB             = 10;
    localparam int S_TDATA_W      = 16;
    localparam int ROW_ELEMS      = 59;
    localparam int NUM_PHASES     = 8;
    localparam int ROWS_PER_PHASE = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int IDLE_PCT       = 28;

    // Module counts per digit, first element in the top nibble.
    localparam logic [15:0] ODD_PATTERN [10] = '{
        16'h3211, 16'h2221, 16'h2122, 16'h1411, 16'h1132,
        16'h1231, 16'h1114, 16'h1312, 16'h1213, 16'h3112};
    localparam logic [15:0] EVEN_PATTERN [10] = '{
        16'h1123, 16'h1222, 16'h2212, 16'h1141, 16'h2311,
        16'h1321, 16'h4111, 16'h2131, 16'h3121, 16'h2113};
    // Left half parity pattern for each lead digit, G as a one.
    localparam logic [5:0] LEAD_PARITY [10] = '{
        6'd0, 6'd11, 6'd13, 6'd14, 6'd19, 6'd25, 6'd28, 6'd21, 6'd22, 6'd26};

    typedef enum int {
        ROW_CLEAN,
        ROW_SPREAD,
        ROW_NOISE
    } row_kind_t;

    typedef struct {
        logic [WB-1:0] width;
        logic          start;
    } element_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
        logic       g;
    } match_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wen;
    logic [15:0]          cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    element_t             pending_elems[$];
    e13ewd_pkg::res_t     expected_digits[$];
    int            idle_pct;
    int            errors;
    int            cycle_count;

    // Predictor state.
    logic [15:0]   span_cfg;
    logic [5:0]    elem_idx;
    logic [WB-1:0] grp_widths [3];
    logic [5:0]    parity_mod;
    logic [5:0]    parity_edge;

    ean13_element_width_decoder #(
        .WIDTH_BITS(WB)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Bounds sit at odd multiples of the span, i.e. at half modules.
    function automatic int unsigned modules_of(input int unsigned c);
        longint unsigned n;
        longint unsigned s;
        n = 190 * longint'(c);
        s = span_cfg;
        if (n >= s && n < 3 * s) return 1;
        if (n >= 3 * s && n < 5 * s) return 2;
        if (n >= 5 * s && n < 7 * s) return 3;
        if (n >= 7 * s && n < 9 * s) return 4;
        return 1;
    endfunction

    // Edge distance in sevenths of the group width, 2 to 5.
    function automatic int unsigned sevenths_of(input int unsigned t, input int unsigned tot);
        if (14 * t < 5 * tot) return 2;
        if (2 * t < tot) return 3;
        if (14 * t < 9 * tot) return 4;
        return 5;
    endfunction

    function automatic match_t module_match(input int unsigned c0, input int unsigned c1,
                                            input int unsigned c2, input int unsigned c3);
        match_t      r;
        int unsigned code;
        r = '0;
        code = (modules_of(c0) << 12) | (modules_of(c1) << 8) |
               (modules_of(c2) << 4) | modules_of(c3);
        for (int d = 0; d < 10; d++) begin
            if (!r.ok && code == ODD_PATTERN[d]) begin
                r = '{ok: 1'b1, digit: 4'(d), g: 1'b0};
            end
        end
        for (int d = 0; d < 10; d++) begin
            if (!r.ok && code == EVEN_PATTERN[d]) begin
                r = '{ok: 1'b1, digit: 4'(d), g: 1'b1};
            end
        end
        return r;
    endfunction

    function automatic match_t edge_match(input int unsigned c0, input int unsigned c1,
                                          input int unsigned c2, input int unsigned c3);
        match_t      r;
        int unsigned tot;
        int unsigned key;
        tot = c0 + c1 + c2 + c3;
        key = sevenths_of(c0 + c1, tot) * 10 + sevenths_of(c1 + c2, tot);
        r = '{ok: 1'b1, digit: 4'd0, g: 1'b0};
        // Digits 1/7 and 2/8 share keys and are told apart by element widths.
        case (key)
            44: r.digit = (c2 > c3) ? 4'd1 : 4'd7;
            33: r.digit = (c1 > c2) ? 4'd8 : 4'd2;
            34: begin
                r.digit = (c0 > c1) ? 4'd7 : 4'd1;
                r.g     = 1'b1;
            end
            43: begin
                r.digit = (c1 > c2) ? 4'd2 : 4'd8;
                r.g     = 1'b1;
            end
            53: r.digit = 4'd0;
            55: r.digit = 4'd3;
            24: r.digit = 4'd4;
            35: r.digit = 4'd5;
            22: r.digit = 4'd6;
            42: r.digit = 4'd9;
            23: r = '{ok: 1'b1, digit: 4'd0, g: 1'b1};
            25: r = '{ok: 1'b1, digit: 4'd3, g: 1'b1};
            54: r = '{ok: 1'b1, digit: 4'd4, g: 1'b1};
            45: r = '{ok: 1'b1, digit: 4'd5, g: 1'b1};
            52: r = '{ok: 1'b1, digit: 4'd6, g: 1'b1};
            32: r = '{ok: 1'b1, digit: 4'd9, g: 1'b1};
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

    function automatic match_t lead_of(input logic [5:0] pattern);
        match_t r;
        r = '0;
        for (int d = 0; d < 10; d++) begin
            if (pattern == LEAD_PARITY[d]) begin
                r = '{ok: 1'b1, digit: 4'(d), g: 1'b0};
            end
        end
        return r;
    endfunction

    task automatic predict_word(input logic [WB-1:0] w, input logic row_start);
        int unsigned      idx;
        int unsigned      rel;
        int unsigned      dpos;
        logic             left;
        match_t           mm;
        match_t           em;
        e13ewd_pkg::res_t r;
        if (row_start) begin
            elem_idx    = '0;
            parity_mod  = '0;
            parity_edge = '0;
        end
        if (elem_idx >= ROW_ELEMS) return;
        idx = elem_idx;
        elem_idx = elem_idx + 6'd1;
        if (idx >= 3 && idx <= 26) begin
            rel  = idx - 3;
            left = 1'b1;
        end else if (idx >= 32 && idx <= 55) begin
            rel  = idx - 32;
            left = 1'b0;
        end else begin
            return;
        end
        if (rel % 4 != 3) begin
            grp_widths[rel % 4] = w;
            return;
        end
        dpos = rel / 4 + (left ? 1 : 7);
        mm = module_match(grp_widths[0], grp_widths[1], grp_widths[2], w);
        em = edge_match(grp_widths[0], grp_widths[1], grp_widths[2], w);
        // Only the left half carries parity; digit 1 is the top bit.
        if (left && mm.ok && mm.g) parity_mod[6 - dpos] = 1'b1;
        if (left && em.ok && em.g) parity_edge[6 - dpos] = 1'b1;
        r.position = 4'(dpos);
        r.done     = 1'b0;
        if (mm.ok) begin
            r.value = mm.digit; r.valid = 1'b1; r.method = e13ewd_pkg::METHOD_MODULE;
        end else if (em.ok) begin
            r.value = em.digit; r.valid = 1'b1; r.method = e13ewd_pkg::METHOD_EDGE;
        end else begin
            r.value = 4'd0; r.valid = 1'b0; r.method = e13ewd_pkg::METHOD_NONE;
        end
        expected_digits.push_back(r);
        if (idx == 55) begin
            mm = lead_of(parity_mod);
            em = lead_of(parity_edge);
            r.position = e13ewd_pkg::POS_LEAD;
            r.done     = 1'b1;
            if (mm.ok) begin
                r.value = mm.digit; r.valid = 1'b1; r.method = e13ewd_pkg::METHOD_MODULE;
            end else if (em.ok) begin
                r.value = em.digit; r.valid = 1'b1; r.method = e13ewd_pkg::METHOD_EDGE;
            end else begin
                r.value = 4'd0; r.valid = 1'b0; r.method = e13ewd_pkg::METHOD_NONE;
            end
            expected_digits.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Width driver: also feeds every accepted word to the predictor.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        element_t e;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            span_cfg      = e13ewd_pkg::SPAN_RESET;
            elem_idx      = '0;
            grp_widths    = '{default: '0};
            parity_mod    = '0;
            parity_edge   = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(s_axis_tdata[WB-1:0], s_axis_tuser[0]);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_elems.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    e = pending_elems.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_TDATA_W'(e.width);
                    s_axis_tuser  <= e.start;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Digit monitor
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        e13ewd_pkg::res_t exp_r;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit word: tdata %h tuser %h tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors++;
                end else begin
                    exp_r = expected_digits.pop_front();
                    check_field("digit_position", exp_r.position, m_axis_tdata[3:0]);
                    check_field("digit_value", exp_r.value, m_axis_tdata[7:4]);
                    check_field("digit_valid", exp_r.valid, m_axis_tuser[0]);
                    check_field("decode_method", exp_r.method, m_axis_tuser[2:1]);
                    check_field("row_done", exp_r.done, m_axis_tlast);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_elem(input int w, input logic row_start);
        element_t e;
        if (w < 0) w = 0;
        if (w > 1023) w = 1023;
        e.width = WB'(w);
        e.start = row_start;
        pending_elems.push_back(e);
    endtask

    // One row from a random digit string; cut < ROW_ELEMS leaves it unfinished.
    task automatic add_row(input row_kind_t kind, input int m, input int cut);
        int          mods [ROW_ELEMS];
        int          lead;
        int          base;
        int          d;
        int          w;
        int          jit;
        int          spread;
        logic [5:0]  par;
        logic [15:0] code;
        lead = $urandom_range(9);
        par  = LEAD_PARITY[lead];
        spread = $urandom_range(m, m / 2 + 1);
        for (int e = 0; e < ROW_ELEMS; e++) mods[e] = 1;
        for (int p = 1; p <= 12; p++) begin
            d = $urandom_range(9);
            base = (p <= 6) ? 3 + 4 * (p - 1) : 32 + 4 * (p - 7);
            code = (p <= 6 && par[6 - p]) ? EVEN_PATTERN[d] : ODD_PATTERN[d];
            for (int j = 0; j < 4; j++) mods[base + j] = code[15 - 4 * j -: 4];
        end
        for (int e = 0; e < cut; e++) begin
            if (kind == ROW_NOISE) begin
                w = $urandom_range(1) ? $urandom_range(1023) : $urandom_range(5 * m);
            end else begin
                jit = $urandom_range(m);
                w = mods[e] * m + jit - m / 2;
                // Ink spread widens bars and narrows spaces; edge sums stay put.
                if (kind == ROW_SPREAD) w = (e % 2 == 0) ? w + spread : w - spread;
            end
            push_elem(w, e == 0);
        end
    endtask

    task automatic write_span(input logic [15:0] v);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        span_cfg  = v;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_elems.size() != 0 || s_axis_tvalid || expected_digits.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int        span;
        int        m;
        int        pick;
        row_kind_t kind;
        cycle_count   = 0;
        errors        = 0;
        idle_pct      = IDLE_PCT;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        aresetn       = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a row begun without a row start right after reset, zero
        // and saturated groups, a clean G digit, tied widths, then a row start
        // in the middle of the row.
        push_elem(1023, 1'b0);
        push_elem(0, 1'b0);
        push_elem(1023, 1'b0);
        for (int j = 0; j < 4; j++) push_elem(0, 1'b0);
        for (int j = 0; j < 4; j++) push_elem(1023, 1'b0);
        push_elem(8, 1'b0);
        push_elem(2, 1'b0);
        push_elem(2, 1'b0);
        push_elem(2, 1'b0);
        for (int j = 0; j < 4; j++) push_elem(2, 1'b0);
        push_elem(512, 1'b1);
        push_elem(341, 1'b0);
        push_elem(682, 1'b0);

        span = e13ewd_pkg::SPAN_RESET;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: span = 95;
                    2: span = 65535;
                    default: span = $urandom_range(1) ? 95 * $urandom_range(255, 2)
                                                      : $urandom_range(24225, 95);
                endcase
                write_span(16'(span));
            end
            idle_pct = (phase == 4) ? 0 : IDLE_PCT;
            m = (span / 95 < 1) ? 1 : span / 95;
            for (int r = 0; r < ROWS_PER_PHASE; r++) begin
                pick = $urandom_range(99);
                if (r == ROWS_PER_PHASE - 1 || pick < 55) kind = ROW_CLEAN;
                else if (pick < 80) kind = ROW_SPREAD;
                else kind = ROW_NOISE;
                // Some rows are cut short, some run past the end guard.
                if (r != ROWS_PER_PHASE - 1 && $urandom_range(99) < 15) begin
                    add_row(kind, m, $urandom_range(ROW_ELEMS - 1, 1));
                end else begin
                    add_row(kind, m, ROW_ELEMS);
                    if ($urandom_range(99) < 25) begin
                        repeat ($urandom_range(4, 1)) push_elem($urandom_range(1023), 1'b0);
                    end
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/e13ewd_pkg.sv
rtl/e13ewd_quant.sv
rtl/e13ewd_digit.sv
rtl/e13ewd_outq.sv
rtl/ean13_element_width_decoder.sv
tb/tb_top.sv
